### sv/psd3_pkg.sv
package psd3_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned DiffW  = 34;   // exact difference of two coordinates
  localparam int unsigned ProdW  = 68;   // product of two differences
  localparam int unsigned SumW   = 69;   // signed sum of three products
  localparam int unsigned LenW   = 68;   // squared segment length
  localparam int unsigned TW     = 32;   // segment parameter, Q0.32
  localparam int unsigned CW     = 35;   // component of point minus nearest point
  localparam int unsigned SqW    = 70;
  localparam int unsigned DistW  = 72;   // squared distance, Q32.32
  localparam int unsigned RootW  = 36;
  localparam int unsigned RootSqW = 74;
  localparam int unsigned OutW   = 32;

  localparam logic [LenW-1:0] ShortSegLimit = LenW'(429496);

  typedef enum logic [1:0] {
    MODE_START = 2'd0,   // nearest point is the segment start
    MODE_END   = 2'd1,   // nearest point is the segment end
    MODE_INNER = 2'd2    // nearest point lies inside the segment
  } mode_t;

  typedef logic signed [DiffW-1:0] diff_t;

endpackage

### sv/point_segment_distance_3d_core.sv
// Distance from a 3D point to a segment, signed Q16.16 coordinates in, unsigned
// Q16.16 distance out, saturating at all ones. Fully pipelined: one beat in and
// one beat out per cycle while the output is not stalled (difference, product, sum
// and classify stages, a 32-stage restoring divider for the segment parameter, offset,
// square and sum stages, a 36-stage square root, output register). A stalled output
// halts the whole pipeline; no beat is lost or repeated.
module point_segment_distance_3d_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // point_x, point_y, point_z, seg_start_x/y/z, seg_end_x/y/z (32 bits each)
  input  logic [287:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // distance (32 bits)
  output logic [31:0] m_tdata
);
  import psd3_pkg::*;

  localparam int unsigned DivN  = TW;
  localparam int unsigned RootN = RootW;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage 1: differences
  logic  v1;
  diff_t d1 [3];
  diff_t w1 [3];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= s_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1[i] <= DiffW'(signed'(s_tdata[(6+i)*CoordW +: CoordW]))
               - DiffW'(signed'(s_tdata[(3+i)*CoordW +: CoordW]));
        w1[i] <= DiffW'(signed'(s_tdata[i*CoordW +: CoordW]))
               - DiffW'(signed'(s_tdata[(3+i)*CoordW +: CoordW]));
      end
    end
  end

  // stage 2: products
  logic v2;
  logic signed [ProdW-1:0] dd2 [3];
  logic signed [ProdW-1:0] wd2 [3];
  diff_t d2 [3];
  diff_t w2 [3];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dd2[i] <= ProdW'(d1[i]) * ProdW'(d1[i]);
        wd2[i] <= ProdW'(w1[i]) * ProdW'(d1[i]);
        d2[i]  <= d1[i];
        w2[i]  <= w1[i];
      end
    end
  end

  // stage 3: sums
  logic v3;
  logic [LenW-1:0] len3;
  logic signed [SumW-1:0] proj3;
  diff_t d3 [3];
  diff_t w3 [3];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      len3  <= LenW'(dd2[0]) + LenW'(dd2[1]) + LenW'(dd2[2]);
      proj3 <= SumW'(wd2[0]) + SumW'(wd2[1]) + SumW'(wd2[2]);
      d3 <= d2;
      w3 <= w2;
    end
  end

  // divider chain: stage 0 classifies, stages 1..32 develop one quotient bit each
  logic            dv   [DivN+1];
  mode_t           dm   [DivN+1];
  logic [LenW-1:0] drem [DivN+1];
  logic [LenW-1:0] dlen [DivN+1];
  logic [TW-1:0]   dt   [DivN+1];
  diff_t           dd   [DivN+1][3];
  diff_t           dw   [DivN+1][3];

  mode_t mode3;
  always_comb begin
    if (len3 <= ShortSegLimit || proj3[SumW-1] || proj3 == '0) begin
      mode3 = MODE_START;
    end else if (proj3 >= signed'({1'b0, len3})) begin
      mode3 = MODE_END;
    end else begin
      mode3 = MODE_INNER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= v3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dm[0]   <= mode3;
      drem[0] <= LenW'(proj3);
      dlen[0] <= len3;
      dt[0]   <= '0;
      dd[0]   <= d3;
      dw[0]   <= w3;
    end
  end

  for (genvar k = 0; k < DivN; k++) begin : g_div
    logic [LenW:0] sh;
    logic          ge;
    assign sh = {drem[k], 1'b0};
    assign ge = sh >= {1'b0, dlen[k]};

    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (en) dv[k+1] <= dv[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        drem[k+1] <= ge ? LenW'(sh - {1'b0, dlen[k]}) : LenW'(sh);
        dt[k+1]   <= {dt[k][TW-2:0], ge};
        dm[k+1]   <= dm[k];
        dlen[k+1] <= dlen[k];
        dd[k+1]   <= dd[k];
        dw[k+1]   <= dw[k];
      end
    end
  end

  // offset stage: c = w - round(t * d), with c = w - d at the end and c = w at the start
  logic v5;
  logic signed [CW-1:0] c5 [3];
  logic [DiffW-1:0] mag_d [3];
  logic [DiffW+TW-1:0] offp [3];
  logic [DiffW-1:0] off [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_d[i] = dd[DivN][i][DiffW-1] ? DiffW'(-dd[DivN][i]) : DiffW'(dd[DivN][i]);
      offp[i]  = (DiffW+TW)'(mag_d[i]) * (DiffW+TW)'(dt[DivN])
               + (DiffW+TW)'(33'h080000000);
      off[i]   = offp[i][DiffW+TW-1:TW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= dv[DivN];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        case (dm[DivN])
          MODE_END:   c5[i] <= CW'(dw[DivN][i]) - CW'(dd[DivN][i]);
          MODE_INNER: c5[i] <= dd[DivN][i][DiffW-1]
                               ? CW'(dw[DivN][i]) + signed'(CW'(off[i]))
                               : CW'(dw[DivN][i]) - signed'(CW'(off[i]));
          default:    c5[i] <= CW'(dw[DivN][i]);
        endcase
      end
    end
  end

  // squares, then sum
  logic v6, v7;
  logic [SqW-1:0] sq6 [3];
  logic [DistW-1:0] sum7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq6[i] <= SqW'(SqW'(c5[i]) * SqW'(c5[i]));
      end
      sum7 <= DistW'(sq6[0]) + DistW'(sq6[1]) + DistW'(sq6[2]);
    end
  end

  // square root chain: one result bit per stage, tracking r and r*r
  logic               rv  [RootN+1];
  logic [DistW-1:0]   rval[RootN+1];
  logic [RootW-1:0]   rr  [RootN+1];
  logic [RootSqW-1:0] rr2 [RootN+1];

  assign rv[0]   = v7;
  assign rval[0] = sum7;
  assign rr[0]   = '0;
  assign rr2[0]  = '0;

  for (genvar k = 0; k < RootN; k++) begin : g_root
    localparam int unsigned B = RootN - 1 - k;
    logic [RootSqW-1:0] cand2;
    logic               take;
    assign cand2 = rr2[k] + (RootSqW'(rr[k]) << (B + 1)) + (RootSqW'(1) << (2 * B));
    assign take  = cand2 <= RootSqW'(rval[k]);

    always_ff @(posedge clk) begin
      if (rst) rv[k+1] <= 1'b0;
      else if (en) rv[k+1] <= rv[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rval[k+1] <= rval[k];
        rr[k+1]   <= take ? (rr[k] | (RootW'(1) << B)) : rr[k];
        rr2[k+1]  <= take ? cand2 : rr2[k];
      end
    end
  end

  // output register with saturation
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (en) m_tvalid <= rv[RootN];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= (rr[RootN][RootW-1:OutW] != '0) ? '1 : rr[RootN][OutW-1:0];
    end
  end

  // a held result freezes the input side
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while output stalled");

  // divider remainder stays below the divisor
  assert property (@(posedge clk) disable iff (rst)
    (dv[1] && dm[1] == MODE_INNER) |-> (drem[1] < dlen[1]))
    else $error("divider remainder out of range");

  // root never exceeds the radicand
  assert property (@(posedge clk) disable iff (rst)
    rv[RootN] |-> (rr2[RootN] <= RootSqW'(rval[RootN])))
    else $error("square root overshoot");

  // output valid is low once reset has been applied
  assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [287:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;

  point_segment_distance_3d_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  localparam int unsigned Latency = 76;
  localparam longint unsigned CycleLimit = 400000;

  typedef logic signed [31:0] coord_t;
  typedef struct {
    coord_t p [3];
    coord_t s [3];
    coord_t e [3];
  } query_t;

  function automatic logic [127:0] mag(logic signed [127:0] x);
    return x < 0 ? -x : x;
  endfunction

  function automatic logic [127:0] sum_sq(logic signed [127:0] v [3]);
    logic [127:0] acc;
    acc = 0;
    for (int i = 0; i < 3; i++) acc += mag(v[i]) * mag(v[i]);
    return acc;
  endfunction

  function automatic logic [31:0] isqrt_sat(logic [127:0] v);
    logic [127:0] r;
    logic [127:0] cand;
    r = 0;
    for (int b = 35; b >= 0; b--) begin
      cand = r | (128'd1 << b);
      if (cand * cand <= v) r = cand;
    end
    return r > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  function automatic logic [31:0] seg_distance(query_t q);
    logic signed [127:0] d [3];
    logic signed [127:0] w [3];
    logic signed [127:0] c [3];
    logic signed [127:0] dot;
    logic [127:0] len2;
    logic [127:0] rem;
    logic [127:0] off;
    logic [31:0] t;
    for (int i = 0; i < 3; i++) begin
      d[i] = 128'(q.e[i]) - 128'(q.s[i]);
      w[i] = 128'(q.p[i]) - 128'(q.s[i]);
      c[i] = w[i];
    end
    len2 = sum_sq(d);
    if (len2 <= 429496) return isqrt_sat(sum_sq(w));
    dot = 0;
    for (int i = 0; i < 3; i++) dot += w[i] * d[i];
    if (dot > 0) begin
      if (dot >= $signed(len2)) begin
        for (int i = 0; i < 3; i++) c[i] = w[i] - d[i];
      end else begin
        rem = dot;
        t = 0;
        for (int i = 0; i < 32; i++) begin
          rem = rem << 1;
          t = t << 1;
          if (rem >= len2) begin
            rem -= len2;
            t[0] = 1'b1;
          end
        end
        for (int i = 0; i < 3; i++) begin
          off = (mag(d[i]) * t + 128'h8000_0000) >> 32;
          c[i] = d[i] < 0 ? w[i] + $signed(off) : w[i] - $signed(off);
        end
      end
    end
    return isqrt_sat(sum_sq(c));
  endfunction

  class distance_scoreboard;
    logic [31:0] pending [$];
    int unsigned mismatches;
    int unsigned seen;

    function void note_query(query_t q);
      pending.push_back(seg_distance(q));
    endfunction

    function void check_distance(logic [31:0] got);
      logic [31:0] want;
      seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %0d: distance %h", seen, got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("beat %0d: distance expected %h got %h", seen, want, got);
      end
    endfunction
  endclass

  distance_scoreboard board;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_recv;
  longint unsigned cycles;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // sample results at the rising edge
  always @(posedge clk)
    if (!rst && m_tvalid && m_tready) board.check_distance(m_tdata);

  // receiver ready, changed on the falling edge
  always @(negedge clk)
    m_tready <= !hold_recv && ($urandom_range(99) >= recv_stall_pct);

  function automatic logic [287:0] pack_query(query_t q);
    logic [287:0] v;
    for (int i = 0; i < 3; i++) begin
      v[32*i +: 32]     = q.p[i];
      v[32*(3+i) +: 32] = q.s[i];
      v[32*(6+i) +: 32] = q.e[i];
    end
    return v;
  endfunction

  // valid stays up after a beat until the next call drives it again
  task automatic send_query(query_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_query(q);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_query(q);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  function automatic coord_t rand_coord(int unsigned span);
    case ($urandom_range(span))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 0;
      3, 4, 5: return $signed($urandom_range(2048)) - 1024;
      6, 7, 8, 9: return $signed($urandom_range(65536 * 200)) - 65536 * 100;
      default: return $urandom;
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int unsigned kind;
    kind = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      q.s[i] = rand_coord(12);
      q.e[i] = rand_coord(12);
      q.p[i] = rand_coord(12);
    end
    // short or degenerate segments
    if (kind == 0)
      for (int i = 0; i < 3; i++) q.e[i] = q.s[i] + $signed($urandom_range(400)) - 200;
    // point near the segment interior
    if (kind >= 6)
      for (int i = 0; i < 3; i++)
        q.p[i] = q.s[i] + ((q.e[i] - q.s[i]) >>> 1) + $signed($urandom_range(4096)) - 2048;
    return q;
  endfunction

  function automatic query_t mk(coord_t p, coord_t s, coord_t e);
    query_t q;
    for (int i = 0; i < 3; i++) begin
      q.p[i] = p;
      q.s[i] = s;
      q.e[i] = e;
    end
    return q;
  endfunction

  task automatic run_phase(int unsigned n, int unsigned idle, int unsigned stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (n) send_query(rand_query());
  endtask

  initial begin
    query_t q;
    board = new();
    cycles = 0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    hold_recv = 1'b0;
    m_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, degenerate segment, before start, beyond end, interior
    send_query(mk(0, 0, 0));
    send_query(mk(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000));
    send_query(mk(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_query(mk(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
    send_query(mk(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF));
    send_query(mk(65536, 0, 0));
    send_query(mk(65536 * 5, 0, 100));
    send_query(mk(65536 * 5, 0, 65));
    send_query(mk(-65536, 0, 65536));
    send_query(mk(65536 * 3, 0, 65536));
    send_query(mk(32768, 0, 65536));
    send_query(mk(-1, 32'sh7FFF_FFFF, 32'sh8000_0000));
    q = mk(0, 0, 0);
    q.e[0] = 65536 * 10;
    q.p[1] = 65536 * 3;
    q.p[0] = 65536 * 4;
    send_query(q);
    q.p[2] = -12345;
    q.p[0] = 65536 * 10;
    send_query(q);
    q = mk(0, 0, 0);
    q.e[1] = 32'sh7FFF_FFFF;
    q.p[0] = 32'sh8000_0000;
    q.p[1] = 77777;
    send_query(q);
    wait_drained();

    run_phase(100, 0, 0);
    run_phase(80, 59, 0);
    run_phase(80, 0, 59);
    run_phase(80, 32, 32);

    // long receiver hold-off while the sender keeps offering; more beats than
    // the pipeline holds, so the input stalls
    fork
      begin
        hold_recv = 1'b1;
        repeat (300) @(posedge clk);
        hold_recv = 1'b0;
      end
      run_phase(100, 0, 0);
    join
    wait_drained();

    repeat (Latency + 20) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
